// ===== design/bdc_pkg.sv =====
// ============================================================================
// bdc_pkg: shared types and constants of the bezier evaluation core
// Field widths of the request and response transactions, command and
// register codes, and the control point load bundle.
// ============================================================================
package bdc_pkg;

   // field widths
   localparam int COORD_W  = 16;
   localparam int IDX_W    = 4;
   localparam int T_W      = 17;
   localparam int SEGF_W   = 4;
   localparam int SAMPLE_W = 12;
   localparam int MODE_W   = 4;
   localparam int NPTS_W   = 5;

   // width of segment start / degree arithmetic (covers 15 * 15 + 15 and 64 points)
   localparam int CALC_W = 10;

   // fraction bits of the incoming t field
   localparam int T_FRAC_IN = 16;

   // t = 1.0 in the incoming format
   localparam logic [T_W-1:0] T_ONE = 17'h10000;

   // command codes
   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_EVAL = 1'b1;

   // register word indexes
   localparam logic REG_SEGMENT_MODE  = 1'b0;
   localparam logic REG_POINTS_IN_USE = 1'b1;

   // control point write into the engine
   typedef struct packed {
      logic                      en;
      logic [IDX_W-1:0]          idx;
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
   } load_type;

endpackage

// ===== design/bezier_de_casteljau_eval_core.sv =====
// ============================================================================
// bezier_de_casteljau_eval_core: bezier curve point evaluation by de Casteljau
// Holds up to MAX_POINTS control points and evaluates one curve point per
// evaluate transaction, whole curve or degree-k segments with shared ends.
// ============================================================================
// A load transaction writes one control point; loads can follow each other
// every cycle while no evaluation is in progress. An evaluate transaction of
// degree D runs the interpolation triangle through the work row memory one
// layer at a time: layer L takes L+1 memory reads and then waits for the
// lerp pipeline to drain, and a segment that fails the range check goes from
// setup straight to the output state without running the engine. The request
// side is stalled while an evaluation is in progress. A finished result sits
// in an output register, so the next request is taken while the previous
// result waits to be collected.
module bezier_de_casteljau_eval_core #(
   parameter int MAX_POINTS  = 16,
   parameter int T_FRAC_BITS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,

   // request channel
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_cmd,
   input  logic        [bdc_pkg::IDX_W-1:0]      req_point_index,
   input  logic signed [bdc_pkg::COORD_W-1:0]    req_point_x,
   input  logic signed [bdc_pkg::COORD_W-1:0]    req_point_y,
   input  logic        [bdc_pkg::T_W-1:0]        req_t_value,
   input  logic        [bdc_pkg::SEGF_W-1:0]     req_segment_index,
   input  logic        [bdc_pkg::SAMPLE_W-1:0]   req_sample_number,

   // response channel
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [bdc_pkg::COORD_W-1:0]    rsp_curve_x,
   output logic signed [bdc_pkg::COORD_W-1:0]    rsp_curve_y,
   output logic        [bdc_pkg::SEGF_W-1:0]     rsp_out_segment,
   output logic        [bdc_pkg::SAMPLE_W-1:0]   rsp_out_sample,
   output logic                                  rsp_segment_error,

   // register port
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic        [2:0]                     csr_paddr,
   input  logic        [31:0]                    csr_pwdata,
   output logic        [31:0]                    csr_prdata,
   output logic                                  csr_pready
);

   localparam int AW = $clog2(MAX_POINTS);
   localparam int CW = bdc_pkg::COORD_W;
   localparam int VW = CW + T_FRAC_BITS;
   localparam int TW = T_FRAC_BITS + 1;
   localparam int KW = bdc_pkg::CALC_W;
   localparam logic [VW-1:0] FRAC_MASK = VW'((64'd1 << T_FRAC_BITS) - 64'd1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SETUP,
      ST_RUN,
      ST_OUT
   } top_state_type;

   top_state_type state_ff;

   logic [bdc_pkg::MODE_W-1:0]   seg_mode_ff;
   logic [bdc_pkg::NPTS_W-1:0]   pts_ff;
   logic                         csr_wr;

   logic [bdc_pkg::SEGF_W-1:0]   job_seg_ff;
   logic [bdc_pkg::T_W-1:0]      job_traw_ff;
   logic [bdc_pkg::SAMPLE_W-1:0] job_sample_ff;
   logic                         job_err_ff;
   logic [AW-1:0]                job_first_ff;
   logic [AW-1:0]                job_deg_ff;
   logic [TW-1:0]                job_t_ff;
   logic                         start_ff;

   logic [KW-1:0]                n_use;
   logic [KW-1:0]                k_use;
   logic [KW-1:0]                seg_start;
   logic [KW-1:0]                seg_deg;
   logic                         seg_err;
   logic [bdc_pkg::T_W-1:0]      t_sat;
   logic [TW-1:0]                t_wide;

   bdc_pkg::load_type            load;
   logic                         eng_done;
   logic signed [VW-1:0]         eng_res_x, eng_res_y;
   logic [VW-1:0]                bias_x, bias_y;
   logic [CW-1:0]                trunc_x, trunc_y;

   logic                         rsp_valid_ff;
   logic signed [CW-1:0]         rsp_curve_x_ff, rsp_curve_y_ff;
   logic [bdc_pkg::SEGF_W-1:0]   rsp_out_segment_ff;
   logic [bdc_pkg::SAMPLE_W-1:0] rsp_out_sample_ff;
   logic                         rsp_segment_error_ff;

   // register port
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         seg_mode_ff <= bdc_pkg::MODE_W'(3);
         pts_ff      <= bdc_pkg::NPTS_W'(4);
      end else if (csr_wr) begin
         case (csr_paddr[2])
            bdc_pkg::REG_SEGMENT_MODE:  seg_mode_ff <= csr_pwdata[bdc_pkg::MODE_W-1:0];
            bdc_pkg::REG_POINTS_IN_USE: pts_ff      <= csr_pwdata[bdc_pkg::NPTS_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[2])
         bdc_pkg::REG_SEGMENT_MODE:  csr_prdata = 32'(seg_mode_ff);
         bdc_pkg::REG_POINTS_IN_USE: csr_prdata = 32'(pts_ff);
         default:                    csr_prdata = '0;
      endcase
   end

   // control point loads go straight to the engine memory
   always_comb begin
      load.en  = req_valid && !req_stall && (req_cmd == bdc_pkg::CMD_LOAD);
      load.idx = req_point_index;
      load.x   = req_point_x;
      load.y   = req_point_y;
   end

   // segment range check and start point
   always_comb begin
      n_use = (KW'(pts_ff) > KW'(MAX_POINTS)) ? KW'(MAX_POINTS) : KW'(pts_ff);
      k_use = (seg_mode_ff <= bdc_pkg::MODE_W'(1)) ? KW'(1) : KW'(seg_mode_ff);
      seg_start = '0;
      seg_deg   = '0;
      if (n_use < KW'(2)) begin
         seg_err = 1'b1;
      end else if (k_use == KW'(1)) begin
         seg_err = (job_seg_ff != '0);
         seg_deg = n_use - 1'b1;
      end else begin
         seg_start = KW'(job_seg_ff) * k_use;
         seg_deg   = k_use;
         seg_err   = (seg_start + k_use) >= n_use;
      end
   end

   // t to the internal fraction width
   assign t_sat = (job_traw_ff > bdc_pkg::T_ONE) ? bdc_pkg::T_ONE : job_traw_ff;

   generate
      if (T_FRAC_BITS >= bdc_pkg::T_FRAC_IN) begin : g_t_up
         assign t_wide = TW'(t_sat) << (T_FRAC_BITS - bdc_pkg::T_FRAC_IN);
      end else begin : g_t_down
         assign t_wide = TW'(t_sat >> (bdc_pkg::T_FRAC_IN - T_FRAC_BITS));
      end
   endgenerate

   // truncate toward zero: bias negative values before the arithmetic shift
   always_comb begin
      bias_x  = eng_res_x + (eng_res_x[VW-1] ? FRAC_MASK : '0);
      bias_y  = eng_res_y + (eng_res_y[VW-1] ? FRAC_MASK : '0);
      trunc_x = bias_x[VW-1:T_FRAC_BITS];
      trunc_y = bias_y[VW-1:T_FRAC_BITS];
   end

   bdc_eval_engine #(
      .MAX_POINTS  (MAX_POINTS),
      .T_FRAC_BITS (T_FRAC_BITS)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .load      (load),
      .job_start (start_ff),
      .job_first (job_first_ff),
      .job_deg   (job_deg_ff),
      .job_t     (job_t_ff),
      .done      (eng_done),
      .res_x     (eng_res_x),
      .res_y     (eng_res_y)
   );

   // transaction control and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         start_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         start_ff <= 1'b0;
         if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            ST_IDLE: begin
               if (req_valid && (req_cmd == bdc_pkg::CMD_EVAL)) begin
                  job_seg_ff    <= req_segment_index;
                  job_traw_ff   <= req_t_value;
                  job_sample_ff <= req_sample_number;
                  state_ff      <= ST_SETUP;
               end
            end
            ST_SETUP: begin
               job_err_ff   <= seg_err;
               job_first_ff <= seg_start[AW-1:0];
               job_deg_ff   <= seg_deg[AW-1:0];
               job_t_ff     <= t_wide;
               if (seg_err) begin
                  state_ff <= ST_OUT;
               end else begin
                  start_ff <= 1'b1;
                  state_ff <= ST_RUN;
               end
            end
            ST_RUN: begin
               if (eng_done) begin
                  state_ff <= ST_OUT;
               end
            end
            ST_OUT: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff         <= 1'b1;
                  rsp_curve_x_ff       <= job_err_ff ? '0 : trunc_x;
                  rsp_curve_y_ff       <= job_err_ff ? '0 : trunc_y;
                  rsp_out_segment_ff   <= job_seg_ff;
                  rsp_out_sample_ff    <= job_sample_ff;
                  rsp_segment_error_ff <= job_err_ff;
                  state_ff             <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req_stall         = (state_ff != ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_curve_x       = rsp_curve_x_ff;
   assign rsp_curve_y       = rsp_curve_y_ff;
   assign rsp_out_segment   = rsp_out_segment_ff;
   assign rsp_out_sample    = rsp_out_sample_ff;
   assign rsp_segment_error = rsp_segment_error_ff;

   // a result appears only out of the output state
   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_OUT))
      else $error("response raised outside output state");

   // engine completes only while a job is running
   a_done_in_run: assert property (@(posedge clock) disable iff (reset)
      eng_done |-> (state_ff == ST_RUN))
      else $error("engine done without a running evaluation");

   // a segment error carries zero coordinates
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_segment_error_ff) |-> (rsp_curve_x_ff == '0 && rsp_curve_y_ff == '0))
      else $error("segment error with nonzero coordinates");

   // an accepted evaluate goes to setup
   a_eval_setup: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_cmd == bdc_pkg::CMD_EVAL) |=> (state_ff == ST_SETUP))
      else $error("evaluate transaction not taken into setup");

endmodule

// ===== design/bdc_lerp_lane.sv =====
// ============================================================================
// bdc_lerp_lane: one coordinate of the interpolation datapath
// Computes a + trunc0((b - a) * t / 2^F) over two register stages:
// difference and magnitude, then the product, then the signed add.
// ============================================================================
module bdc_lerp_lane #(
   parameter int T_FRAC_BITS = 16
) (
   input  logic                                          clock,
   input  logic signed [bdc_pkg::COORD_W+T_FRAC_BITS-1:0] a_in,
   input  logic signed [bdc_pkg::COORD_W+T_FRAC_BITS-1:0] b_in,
   input  logic        [T_FRAC_BITS:0]                   t_in,
   output logic signed [bdc_pkg::COORD_W+T_FRAC_BITS-1:0] res_out
);

   localparam int VW = bdc_pkg::COORD_W + T_FRAC_BITS;
   localparam int TW = T_FRAC_BITS + 1;
   localparam int PW = VW + TW;

   logic [VW:0]          diff;
   logic [VW:0]          diff_mag;
   logic                 diff_neg;
   logic [VW-1:0]        mag_ff;
   logic                 neg1_ff;
   logic [VW-1:0]        a1_ff;
   logic [PW-1:0]        prod_ff;
   logic                 neg2_ff;
   logic [VW-1:0]        a2_ff;
   logic [VW-1:0]        q;
   logic [VW:0]          sum;

   // signed difference and its magnitude
   always_comb begin
      diff     = {b_in[VW-1], b_in} - {a_in[VW-1], a_in};
      diff_neg = diff[VW];
      diff_mag = diff_neg ? (~diff + 1'b1) : diff;
   end

   // magnitude stage, then multiply stage
   always_ff @(posedge clock) begin
      mag_ff  <= diff_mag[VW-1:0];
      neg1_ff <= diff_neg;
      a1_ff   <= a_in;
      prod_ff <= PW'(mag_ff) * PW'(t_in);
      neg2_ff <= neg1_ff;
      a2_ff   <= a1_ff;
   end

   // scale back and step from a toward b
   always_comb begin
      q   = prod_ff[VW+T_FRAC_BITS-1:T_FRAC_BITS];
      sum = neg2_ff ? ({a2_ff[VW-1], a2_ff} - {1'b0, q})
                    : ({a2_ff[VW-1], a2_ff} + {1'b0, q});
      res_out = sum[VW-1:0];
   end

endmodule

// ===== design/bdc_eval_engine.sv =====
// ============================================================================
// bdc_eval_engine: control point memory, work row memory and layer sequencer
// Streams one layer of the de Casteljau triangle per pass: reads entries in
// order, interpolates neighbors and writes the row back in place. The first
// layer reads the control point memory directly. Between layers the pipeline
// drains so that the next pass never reads an entry still in flight.
// ============================================================================
module bdc_eval_engine #(
   parameter int MAX_POINTS  = 16,
   parameter int T_FRAC_BITS = 16
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  bdc_pkg::load_type                             load,
   input  logic                                          job_start,
   input  logic        [$clog2(MAX_POINTS)-1:0]          job_first,
   input  logic        [$clog2(MAX_POINTS)-1:0]          job_deg,
   input  logic        [T_FRAC_BITS:0]                   job_t,
   output logic                                          done,
   output logic signed [bdc_pkg::COORD_W+T_FRAC_BITS-1:0] res_x,
   output logic signed [bdc_pkg::COORD_W+T_FRAC_BITS-1:0] res_y
);

   localparam int AW = $clog2(MAX_POINTS);
   localparam int CW = bdc_pkg::COORD_W;
   localparam int VW = CW + T_FRAC_BITS;

   typedef enum logic [1:0] {
      E_IDLE,
      E_ISSUE,
      E_DRAIN
   } eng_state_type;

   eng_state_type state_ff;

   logic [2*CW-1:0] cp_mem [MAX_POINTS];
   logic [2*VW-1:0] wk_mem [MAX_POINTS];
   logic [2*CW-1:0] cp_rd_ff;
   logic [2*VW-1:0] wk_rd_ff;

   logic [AW-1:0] layer_ff;
   logic [AW-1:0] rd_cnt_ff;
   logic          from_cp_ff;
   logic          issue;
   logic [AW-1:0] cp_raddr;
   logic          ld_ok;
   logic [AW-1:0] ld_addr;

   logic          s1_vld_ff, s2_vld_ff, s3_vld_ff;
   logic          s1_first_ff;
   logic          s1_cp_ff;
   logic [AW-1:0] s1_waddr_ff, s2_waddr_ff, s3_waddr_ff;
   logic          s1_last_ff, s2_last_ff, s3_last_ff;

   logic signed [VW-1:0] cur_x, cur_y;
   logic signed [VW-1:0] prev_x_ff, prev_y_ff;
   logic signed [VW-1:0] lane_x, lane_y;
   logic signed [VW-1:0] res_x_ff, res_y_ff;
   logic                 done_ff;

   // read issue
   assign issue    = (state_ff == E_ISSUE);
   assign cp_raddr = job_first + rd_cnt_ff;
   assign ld_ok    = load.en && (32'(load.idx) < 32'(MAX_POINTS));
   assign ld_addr  = AW'(load.idx);

   // control point memory
   always_ff @(posedge clock) begin
      if (ld_ok) begin
         cp_mem[ld_addr] <= {load.x, load.y};
      end
      cp_rd_ff <= cp_mem[cp_raddr];
   end

   // work row memory, written back from the last pipeline stage
   always_ff @(posedge clock) begin
      if (s3_vld_ff) begin
         wk_mem[s3_waddr_ff] <= {lane_x, lane_y};
      end
      wk_rd_ff <= wk_mem[rd_cnt_ff];
   end

   // current entry: scaled control point or work row entry
   always_comb begin
      if (s1_cp_ff) begin
         cur_x = {cp_rd_ff[2*CW-1:CW], {T_FRAC_BITS{1'b0}}};
         cur_y = {cp_rd_ff[CW-1:0], {T_FRAC_BITS{1'b0}}};
      end else begin
         cur_x = wk_rd_ff[2*VW-1:VW];
         cur_y = wk_rd_ff[VW-1:0];
      end
   end

   // interpolation lanes
   bdc_lerp_lane #(.T_FRAC_BITS(T_FRAC_BITS)) u_lane_x (
      .clock   (clock),
      .a_in    (prev_x_ff),
      .b_in    (cur_x),
      .t_in    (job_t),
      .res_out (lane_x)
   );

   bdc_lerp_lane #(.T_FRAC_BITS(T_FRAC_BITS)) u_lane_y (
      .clock   (clock),
      .a_in    (prev_y_ff),
      .b_in    (cur_y),
      .t_in    (job_t),
      .res_out (lane_y)
   );

   // sequencer and pipeline control
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= E_IDLE;
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         done_ff <= 1'b0;

         s1_vld_ff   <= issue;
         s1_first_ff <= (rd_cnt_ff == '0);
         s1_cp_ff    <= from_cp_ff;
         s1_waddr_ff <= rd_cnt_ff - 1'b1;
         s1_last_ff  <= (layer_ff == AW'(1));

         s2_vld_ff   <= s1_vld_ff && !s1_first_ff;
         s2_waddr_ff <= s1_waddr_ff;
         s2_last_ff  <= s1_last_ff;

         s3_vld_ff   <= s2_vld_ff;
         s3_waddr_ff <= s2_waddr_ff;
         s3_last_ff  <= s2_last_ff;

         if (s1_vld_ff) begin
            prev_x_ff <= cur_x;
            prev_y_ff <= cur_y;
         end

         // the final layer leaves the curve point
         if (s3_vld_ff && s3_last_ff) begin
            res_x_ff <= lane_x;
            res_y_ff <= lane_y;
         end

         case (state_ff)
            E_IDLE: begin
               if (job_start) begin
                  layer_ff   <= job_deg;
                  rd_cnt_ff  <= '0;
                  from_cp_ff <= 1'b1;
                  state_ff   <= E_ISSUE;
               end
            end
            E_ISSUE: begin
               if (rd_cnt_ff == layer_ff) begin
                  state_ff <= E_DRAIN;
               end else begin
                  rd_cnt_ff <= rd_cnt_ff + 1'b1;
               end
            end
            E_DRAIN: begin
               // wait for the last write-back of the layer
               if (!s1_vld_ff && !s2_vld_ff && !s3_vld_ff) begin
                  if (layer_ff == AW'(1)) begin
                     done_ff  <= 1'b1;
                     state_ff <= E_IDLE;
                  end else begin
                     layer_ff   <= layer_ff - 1'b1;
                     rd_cnt_ff  <= '0;
                     from_cp_ff <= 1'b0;
                     state_ff   <= E_ISSUE;
                  end
               end
            end
            default: begin
               state_ff <= E_IDLE;
            end
         endcase
      end
   end

   assign done  = done_ff;
   assign res_x = res_x_ff;
   assign res_y = res_y_ff;

   // a new pass starts only on an empty pipeline
   a_pass_interlock: assert property (@(posedge clock) disable iff (reset)
      (state_ff == E_ISSUE && rd_cnt_ff == '0) |-> (!s1_vld_ff && !s2_vld_ff && !s3_vld_ff))
      else $error("layer pass started with writes still in flight");

   // completion only after the last layer drains
   a_done_after_last: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> ($past(state_ff == E_DRAIN) && $past(layer_ff == AW'(1))))
      else $error("done without draining the final layer");

   // no write-back outside a job
   a_write_in_job: assert property (@(posedge clock) disable iff (reset)
      s3_vld_ff |-> (state_ff != E_IDLE))
      else $error("work row write while engine idle");

endmodule

// ===== bench/testbench.sv =====
// ============================================================================
// testbench: self-checking bench for bezier_de_casteljau_eval_core
// Loads control points, evaluates curve points over whole-curve and segment
// modes under random idling on both channels, and checks every response
// transaction against a bit-accurate de Casteljau predictor kept in the bench.
// ============================================================================
module testbench;
   import bdc_pkg::*;

   localparam int MAX_POINTS   = 16;
   // drain time sized for the longest evaluation (degree 15)
   localparam int DRAIN_CYCLES = 210;
   localparam int PHASE_ITEMS  = 125;
   localparam int REPORT_LIMIT = 10;

   typedef struct {
      logic                      cmd;
      logic [IDX_W-1:0]          idx;
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic [T_W-1:0]            t;
      logic [SEGF_W-1:0]         seg;
      logic [SAMPLE_W-1:0]       sample;
   } request_t;

   typedef struct {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic [SEGF_W-1:0]         segment;
      logic [SAMPLE_W-1:0]       sample;
      logic                      err;
   } curve_point_t;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic                      req_cmd = CMD_LOAD;
   logic [IDX_W-1:0]          req_point_index = '0;
   logic signed [COORD_W-1:0] req_point_x = '0;
   logic signed [COORD_W-1:0] req_point_y = '0;
   logic [T_W-1:0]            req_t_value = '0;
   logic [SEGF_W-1:0]         req_segment_index = '0;
   logic [SAMPLE_W-1:0]       req_sample_number = '0;

   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic signed [COORD_W-1:0] rsp_curve_x;
   logic signed [COORD_W-1:0] rsp_curve_y;
   logic [SEGF_W-1:0]         rsp_out_segment;
   logic [SAMPLE_W-1:0]       rsp_out_sample;
   logic                      rsp_segment_error;

   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // bench copy of the block state
   logic signed [COORD_W-1:0] point_x [MAX_POINTS];
   logic signed [COORD_W-1:0] point_y [MAX_POINTS];
   logic [MODE_W-1:0]         mode_reg = 4'd3;
   logic [NPTS_W-1:0]         points_reg = 5'd4;

   curve_point_t expected_points [$];
   int  mismatch_count = 0;
   bit  idling_on = 1'b1;
   int  hold_count = 0;
   int  stall_left = 0;

   bezier_de_casteljau_eval_core dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_cmd           (req_cmd),
      .req_point_index   (req_point_index),
      .req_point_x       (req_point_x),
      .req_point_y       (req_point_y),
      .req_t_value       (req_t_value),
      .req_segment_index (req_segment_index),
      .req_sample_number (req_sample_number),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_curve_x       (rsp_curve_x),
      .rsp_curve_y       (rsp_curve_y),
      .rsp_out_segment   (rsp_out_segment),
      .rsp_out_sample    (rsp_out_sample),
      .rsp_segment_error (rsp_segment_error),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready)
   );

   always #1 clock = ~clock;

   // gap length: mostly none or short, now and then long
   function automatic int idle_length();
      int r;
      r = $urandom_range(0, 99);
      if (!idling_on || r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // one interpolation step, truncated toward zero so it stays between a and b
   function automatic logic signed [63:0] lerp_step(logic signed [63:0] a,
                                                    logic signed [63:0] b,
                                                    logic [T_W-1:0] t);
      logic signed [63:0] diff;
      logic [63:0]        mag;
      logic [63:0]        step;
      diff = b - a;
      mag  = (diff < 0) ? -diff : diff;
      step = (mag * t) >> T_FRAC_IN;
      return (diff < 0) ? a - $signed(step) : a + $signed(step);
   endfunction

   // drop fraction bits, truncating toward zero
   function automatic logic signed [COORD_W-1:0] to_pixel(logic signed [63:0] v);
      logic [63:0] mag;
      logic [63:0] q;
      mag = (v < 0) ? -v : v;
      q   = mag >> T_FRAC_IN;
      if (v < 0) q = -q;
      return q[COORD_W-1:0];
   endfunction

   // number of segments that pass the range check under the current settings
   function automatic int segments_in_range();
      int n, k;
      n = (points_reg > MAX_POINTS) ? MAX_POINTS : points_reg;
      k = (mode_reg <= 1) ? 1 : mode_reg;
      if (n < 2) return 0;
      if (k == 1) return 1;
      if (n <= k) return 0;
      return (n - k - 1) / k + 1;
   endfunction

   // curve point of one evaluate transaction
   function automatic curve_point_t evaluate_point(logic [SEGF_W-1:0] seg,
                                                   logic [T_W-1:0] t_raw,
                                                   logic [SAMPLE_W-1:0] sample);
      curve_point_t       res;
      logic signed [63:0] row_x [MAX_POINTS];
      logic signed [63:0] row_y [MAX_POINTS];
      logic [T_W-1:0]     t;
      int                 n, k, start, deg, layer, j;
      bit                 bad;
      t = (t_raw > T_ONE) ? T_ONE : t_raw;
      n = (points_reg > MAX_POINTS) ? MAX_POINTS : points_reg;
      k = (mode_reg <= 1) ? 1 : mode_reg;
      start = 0;
      deg = 0;
      bad = 1'b0;
      if (n < 2) begin
         bad = 1'b1;
      end else if (k == 1) begin
         bad = (seg != 0);
         deg = n - 1;
      end else begin
         start = int'(seg) * k;
         deg = k;
         bad = (start + k >= n);
      end
      res.x = '0;
      res.y = '0;
      res.segment = seg;
      res.sample = sample;
      res.err = bad;
      if (!bad) begin
         for (j = 0; j <= deg; j++) begin
            row_x[j] = point_x[start + j];
            row_y[j] = point_y[start + j];
            row_x[j] = row_x[j] <<< T_FRAC_IN;
            row_y[j] = row_y[j] <<< T_FRAC_IN;
         end
         for (layer = deg; layer > 0; layer--) begin
            for (j = 0; j < layer; j++) begin
               row_x[j] = lerp_step(row_x[j], row_x[j + 1], t);
               row_y[j] = lerp_step(row_y[j], row_y[j + 1], t);
            end
         end
         res.x = to_pixel(row_x[0]);
         res.y = to_pixel(row_y[0]);
      end
      return res;
   endfunction

   // offer one request transaction, update the bench state on acceptance
   task automatic send_request(input request_t item);
      int gap;
      req_valid         <= 1'b1;
      req_cmd           <= item.cmd;
      req_point_index   <= item.idx;
      req_point_x       <= item.x;
      req_point_y       <= item.y;
      req_t_value       <= item.t;
      req_segment_index <= item.seg;
      req_sample_number <= item.sample;
      do @(posedge clock); while (req_stall);
      if (item.cmd == CMD_LOAD) begin
         point_x[item.idx] = item.x;
         point_y[item.idx] = item.y;
      end else begin
         expected_points.push_back(evaluate_point(item.seg, item.t, item.sample));
      end
      gap = idle_length();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic load_point(input int idx, input int x, input int y);
      request_t item;
      item.cmd = CMD_LOAD;
      item.idx = idx;
      item.x = x;
      item.y = y;
      item.t = $urandom_range(0, 131071);
      item.seg = $urandom_range(0, 15);
      item.sample = $urandom_range(0, 4095);
      send_request(item);
   endtask

   task automatic evaluate(input int seg, input int t);
      request_t item;
      item.cmd = CMD_EVAL;
      item.idx = $urandom_range(0, 15);
      item.x = $urandom_range(0, 65535);
      item.y = $urandom_range(0, 65535);
      item.t = t;
      item.seg = seg;
      item.sample = $urandom_range(0, 4095);
      send_request(item);
   endtask

   // stop offering, let every expected response arrive and the core settle
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_points.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // register write: setup cycle, then access cycle until pready
   task automatic write_register(input logic index, input int value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (index == REG_SEGMENT_MODE) mode_reg = value;
      else points_reg = value;
   endtask

   task automatic configure(input int mode, input int points);
      wait_idle();
      write_register(REG_SEGMENT_MODE, mode);
      write_register(REG_POINTS_IN_USE, points);
   endtask

   // fill every slot, extremes in the first ones
   task automatic test_point_load();
      int i;
      load_point(0, -32768, 32767);
      load_point(1, 32767, -32768);
      load_point(2, -32768, -32768);
      load_point(3, 32767, 32767);
      load_point(4, 0, -1);
      load_point(5, -1, 0);
      for (i = 6; i < MAX_POINTS; i++)
         load_point(i, $urandom_range(0, 65535), $urandom_range(0, 65535));
   endtask

   // t ends, t above one, mode zero, saturated and too few points, range check
   task automatic test_special_cases();
      evaluate(0, 0);
      evaluate(0, 65536);
      evaluate(0, 131071);
      evaluate(0, 1);
      evaluate(1, 32768);
      evaluate(15, 32768);
      configure(1, 16);
      evaluate(0, 32768);
      evaluate(5, 1000);
      configure(0, 31);
      evaluate(0, 12345);
      configure(2, 1);
      evaluate(0, 30000);
      configure(2, 0);
      evaluate(0, 30000);
      configure(15, 16);
      evaluate(0, 40000);
      evaluate(1, 40000);
      configure(15, 15);
      evaluate(0, 40000);
   endtask

   // response side held off long enough for the core to back up
   task automatic test_backpressure();
      int i;
      configure(3, 16);
      idling_on = 1'b0;
      hold_count = 300;
      for (i = 0; i < 24; i++) begin
         if (i % 4 == 3) load_point($urandom_range(0, 15), $urandom_range(0, 65535),
                                    $urandom_range(0, 65535));
         else evaluate($urandom_range(0, 4), $urandom_range(0, 65536));
      end
      idling_on = 1'b1;
   endtask

   // random mix of loads and evaluations under one setting
   task automatic test_random_phase(input int mode, input int points, input bit idle);
      int i, r, segs, seg, t, cx, cy;
      configure(mode, points);
      idling_on = idle;
      for (i = 0; i < PHASE_ITEMS; i++) begin
         r = $urandom_range(0, 99);
         if (r < 30) begin
            cx = $urandom_range(0, 65535);
            cy = $urandom_range(0, 65535);
            if ($urandom_range(0, 99) < 15) cx = $urandom_range(0, 1) ? -32768 : 32767;
            if ($urandom_range(0, 99) < 15) cy = $urandom_range(0, 1) ? 0 : -1;
            load_point($urandom_range(0, 15), cx, cy);
         end else begin
            segs = segments_in_range();
            if (segs > 0 && $urandom_range(0, 99) < 85) seg = $urandom_range(0, segs - 1);
            else seg = $urandom_range(0, 15);
            r = $urandom_range(0, 99);
            if (r < 10) t = 0;
            else if (r < 20) t = 65536;
            else if (r < 28) t = $urandom_range(65537, 131071);
            else t = $urandom_range(0, 65536);
            evaluate(seg, t);
         end
      end
      idling_on = 1'b1;
   endtask

   // response stall: long hold-off when asked, random gaps otherwise
   always @(posedge clock) begin
      if (hold_count > 0) begin
         rsp_stall <= 1'b1;
         hold_count--;
      end else if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else begin
         rsp_stall <= 1'b0;
         stall_left = idle_length();
      end
   end

   // compare each response transaction with the oldest expected point
   always @(posedge clock) begin
      curve_point_t want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_points.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
               $display("unexpected response: x=%0d y=%0d seg=%0d sample=%0d err=%0b",
                        rsp_curve_x, rsp_curve_y, rsp_out_segment, rsp_out_sample,
                        rsp_segment_error);
         end else begin
            want = expected_points.pop_front();
            if (rsp_curve_x !== want.x || rsp_curve_y !== want.y ||
                rsp_out_segment !== want.segment || rsp_out_sample !== want.sample ||
                rsp_segment_error !== want.err) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display("mismatch: expected x=%0d y=%0d seg=%0d sample=%0d err=%0b, %s",
                           want.x, want.y, want.segment, want.sample, want.err,
                           $sformatf("got x=%0d y=%0d seg=%0d sample=%0d err=%0b",
                                     rsp_curve_x, rsp_curve_y, rsp_out_segment,
                                     rsp_out_sample, rsp_segment_error));
            end
         end
      end
   end

   // run limit
   initial begin
      #4000000;
      $display("Some tests failed");
      $finish;
   end

   initial begin
      int phase;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_point_load();
      test_special_cases();
      test_backpressure();
      test_random_phase(3, 16, 1'b1);
      test_random_phase(1, 2, 1'b0);
      test_random_phase(15, 16, 1'b1);
      test_random_phase(2, 16, 1'b1);
      test_random_phase(0, 8, 1'b0);
      test_random_phase(1, 16, 1'b1);
      for (phase = 0; phase < 4; phase++)
         test_random_phase(($urandom_range(0, 1) != 0) ? $urandom_range(2, 4)
                                                       : $urandom_range(0, 15),
                           ($urandom_range(0, 99) < 60) ? 16 : $urandom_range(0, 31),
                           phase != 1);
      wait_idle();
      if (mismatch_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

// ===== files.f =====
design/bdc_pkg.sv
design/bdc_lerp_lane.sv
design/bdc_eval_engine.sv
design/bezier_de_casteljau_eval_core.sv
bench/testbench.sv
